/* rtl/plce_pkg.sv */
package plce_pkg;

    localparam int OPCODE_W  = 5;
    localparam int FLAG_IDX_W = 10;
    localparam int LATCH_IDX_W = 8;
    localparam int TIMER_IDX_W = 6;
    localparam int PRESET_W  = 16;
    localparam int SAMPLE_W  = 8;
    localparam int COUNT_W   = 16;
    localparam int DECODE_SPAN = 8;

    localparam int DEF_NUM_FLAGS   = 1024;
    localparam int DEF_NUM_LATCHES = 256;
    localparam int DEF_NUM_TIMERS  = 64;
    localparam int DEF_TIMER_WIDTH = 16;

    typedef enum logic [OPCODE_W-1:0] {
        OP_SET     = 5'd0,
        OP_CLR     = 5'd1,
        OP_COPY    = 5'd2,
        OP_TOGGLE  = 5'd3,
        OP_DELAY1  = 5'd4,
        OP_DELAY2  = 5'd5,
        OP_DELAY3  = 5'd6,
        OP_DELAY4  = 5'd7,
        OP_DELAY5  = 5'd8,
        OP_ABOVE   = 5'd9,
        OP_BELOW   = 5'd10,
        OP_PULSE   = 5'd11,
        OP_OR      = 5'd12,
        OP_AND     = 5'd13,
        OP_NOT     = 5'd14,
        OP_DEMUX   = 5'd15,
        OP_ZERO    = 5'd16,
        OP_ONE     = 5'd17,
        OP_LOCKOUT = 5'd18
    } plce_op_e;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD1,
        ST_RD2,
        ST_RD3,
        ST_EXEC,
        ST_WOB,
        ST_DEC,
        ST_RB,
        ST_CAP
    } plce_state_t;

    typedef struct packed {
        logic [OPCODE_W-1:0]    opcode;
        logic [FLAG_IDX_W-1:0]  out_a;
        logic [FLAG_IDX_W-1:0]  out_b;
        logic [FLAG_IDX_W-1:0]  in_a;
        logic [FLAG_IDX_W-1:0]  in_b;
        logic [FLAG_IDX_W-1:0]  in_c;
        logic [FLAG_IDX_W-1:0]  in_d;
        logic [LATCH_IDX_W-1:0] latch_index;
        logic [TIMER_IDX_W-1:0] timer_index;
        logic [PRESET_W-1:0]    preset_time;
        logic [SAMPLE_W-1:0]    analog_sample;
    } plce_cmd_t;

    typedef struct packed {
        logic               first_out_value;
        logic               second_out_value;
        logic [COUNT_W-1:0] counter_after;
        logic               first_in_value;
    } plce_rsp_t;

    // decisions of the execute step
    typedef struct packed {
        logic wr_oa;
        logic oa_val;
        logic wr_ob;
        logic demux;
        logic lat_val;
        logic tmr_load;
        logic tmr_dec;
    } plce_ctl_t;

    // index wrap by restoring compare/subtract; quotient stays below 128
    function automatic logic [16:0] fold_index(input logic [15:0] v, input logic [16:0] m);
        logic [23:0] r;
        logic [23:0] ms;
        r = {8'd0, v};
        for (int s = 6; s >= 0; s--) begin
            ms = {7'd0, m} << s;
            if (r >= ms) begin
                r = r - ms;
            end
        end
        return r[16:0];
    endfunction

endpackage

/* rtl/plce_ram_1r.sv */
module plce_ram_1r
    import plce_pkg::*;
#(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/plce_ram_2r.sv */
module plce_ram_2r
    import plce_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic          wdata,
    input  logic [AW-1:0] raddr0,
    input  logic [AW-1:0] raddr1,
    output logic          rdata0,
    output logic          rdata1
);

    logic mem [DEPTH];
    logic rdata0_reg;
    logic rdata1_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata0_reg <= mem[raddr0];
        rdata1_reg <= mem[raddr1];
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;

endmodule

/* rtl/plce_exec.sv */
module plce_exec
    import plce_pkg::*;
(
    input  logic [OPCODE_W-1:0]   op,
    input  logic                  fa,
    input  logic                  fb,
    input  logic                  fc,
    input  logic                  fd,
    input  logic                  fo,
    input  logic                  ia_is_oa,
    input  logic                  lat,
    input  logic                  nz,
    input  logic [SAMPLE_W-1:0]   smp,
    input  logic [FLAG_IDX_W-1:0] raw_c,
    input  logic [FLAG_IDX_W-1:0] raw_d,
    output plce_ctl_t             ctl
);

    logic smp_gt_d;
    logic smp_lt_d;
    logic smp_gt_c;
    logic smp_lt_c;
    logic lat_kept;
    logic fa_late;

    assign smp_gt_d = {2'd0, smp} > raw_d;
    assign smp_lt_d = {2'd0, smp} < raw_d;
    assign smp_gt_c = {2'd0, smp} > raw_c;
    assign smp_lt_c = {2'd0, smp} < raw_c;
    // pulse: latch drops first; in_a is re-read after out_a has been cleared
    assign lat_kept = fa & lat;
    assign fa_late  = fa & ~ia_is_oa;

    always_comb
    begin
        ctl          = '0;
        ctl.lat_val  = lat;
        unique case (op)
            OP_SET:
            begin
                ctl.wr_oa  = fa;
                ctl.oa_val = 1'b1;
            end
            OP_CLR:
            begin
                ctl.wr_oa  = fa;
                ctl.oa_val = 1'b0;
            end
            OP_COPY:
            begin
                ctl.wr_oa  = 1'b1;
                ctl.oa_val = fa;
            end
            OP_TOGGLE:
            begin
                if (!fa)
                begin
                    ctl.tmr_dec = nz;
                end
                else
                begin
                    ctl.wr_oa    = ~nz;
                    ctl.oa_val   = ~fo;
                    ctl.tmr_load = 1'b1;
                end
            end
            OP_DELAY1:
            begin
                ctl.wr_oa = 1'b1;
                if (fb)
                begin
                    ctl.tmr_load = 1'b1;
                end
                else if (nz)
                begin
                    ctl.tmr_dec = 1'b1;
                end
                else
                begin
                    ctl.oa_val = fa;
                end
            end
            OP_DELAY2, OP_DELAY3:
            begin
                ctl.wr_oa = 1'b1;
                if ((op == OP_DELAY2) ? fb : fa)
                begin
                    ctl.tmr_dec = nz;
                    ctl.oa_val  = ~nz & fa;
                end
                else
                begin
                    ctl.tmr_load = 1'b1;
                end
            end
            OP_DELAY4:
            begin
                ctl.wr_oa = 1'b1;
                if (fa | fb)
                begin
                    ctl.tmr_dec = nz;
                    ctl.oa_val  = ~nz;
                end
                else
                begin
                    ctl.tmr_load = 1'b1;
                end
            end
            OP_DELAY5:
            begin
                ctl.wr_oa = 1'b1;
                if (fc)
                begin
                    ctl.tmr_dec = nz;
                    ctl.oa_val  = ~nz & fa;
                end
                else if (fd)
                begin
                    ctl.tmr_dec = nz;
                    ctl.oa_val  = ~nz & fb;
                end
                else
                begin
                    ctl.tmr_load = 1'b1;
                end
            end
            OP_ABOVE:
            begin
                ctl.wr_oa  = fo ? smp_lt_c : smp_gt_d;
                ctl.oa_val = ~fo;
            end
            OP_BELOW:
            begin
                ctl.wr_oa  = fo ? smp_gt_c : smp_lt_d;
                ctl.oa_val = ~fo;
            end
            OP_PULSE:
            begin
                ctl.wr_oa   = 1'b1;
                ctl.lat_val = lat_kept;
                if (nz)
                begin
                    ctl.tmr_dec = 1'b1;
                    ctl.oa_val  = 1'b1;
                end
                else if (!lat_kept && fa_late)
                begin
                    ctl.oa_val   = 1'b1;
                    ctl.lat_val  = 1'b1;
                    ctl.tmr_load = 1'b1;
                end
            end
            OP_OR:
            begin
                ctl.wr_oa  = 1'b1;
                ctl.oa_val = fa | fb;
            end
            OP_AND:
            begin
                ctl.wr_oa  = 1'b1;
                ctl.oa_val = fa & fb;
            end
            OP_NOT:
            begin
                ctl.wr_oa  = 1'b1;
                ctl.oa_val = ~fa;
            end
            OP_DEMUX:
            begin
                ctl.demux = 1'b1;
            end
            OP_ZERO:
            begin
                ctl.wr_oa  = 1'b1;
                ctl.oa_val = 1'b0;
            end
            OP_ONE:
            begin
                ctl.wr_oa  = 1'b1;
                ctl.oa_val = 1'b1;
            end
            OP_LOCKOUT:
            begin
                if (lat)
                begin
                    ctl.wr_oa = 1'b1;
                    ctl.wr_ob = 1'b1;
                    if (nz)
                    begin
                        ctl.tmr_load = fa | fb;
                        ctl.tmr_dec  = ~(fa | fb);
                    end
                    else
                    begin
                        ctl.lat_val = 1'b0;
                    end
                end
                else if (fa & fb)
                begin
                    ctl.wr_oa    = 1'b1;
                    ctl.wr_ob    = 1'b1;
                    ctl.lat_val  = 1'b1;
                    ctl.tmr_load = 1'b1;
                end
            end
            default:
            begin
                ctl.wr_oa = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/plc_logic_instruction_engine.sv */
// channel  | direction | handshake           | payload
// command  | in        | start & !busy       | cmd    (plce_cmd_t)
// result   | out       | done, one cycle     | result (plce_rsp_t)
//
// An item runs RD1, RD2, RD3, EXEC, RB, CAP; WOB is added when lockout clears out_b
// (extra write of out_b) and DEC for demux (eight flag writes); the single write port of the
// flag memory sets this. busy falls with done, so an item cannot start before the last is done.
// After reset the memories are cleared one entry a cycle over max(NUM_FLAGS, NUM_LATCHES,
// NUM_TIMERS) entries (1024 by default) with busy high.
// The receiver cannot stall: done is a single-cycle strobe.
module plc_logic_instruction_engine
    import plce_pkg::*;
#(
    parameter int NUM_FLAGS   = DEF_NUM_FLAGS,
    parameter int NUM_LATCHES = DEF_NUM_LATCHES,
    parameter int NUM_TIMERS  = DEF_NUM_TIMERS,
    parameter int TIMER_WIDTH = DEF_TIMER_WIDTH
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  plce_cmd_t cmd,
    output logic      done,
    output plce_rsp_t result
);

    localparam int FW = (NUM_FLAGS > 1) ? $clog2(NUM_FLAGS) : 1;
    localparam int LW = (NUM_LATCHES > 1) ? $clog2(NUM_LATCHES) : 1;
    localparam int XW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int TW = TIMER_WIDTH;
    localparam int CLR_A = (NUM_FLAGS > NUM_LATCHES) ? NUM_FLAGS : NUM_LATCHES;
    localparam int CLR_LEN = (CLR_A > NUM_TIMERS) ? CLR_A : NUM_TIMERS;
    localparam int CW = $clog2(CLR_LEN);

    plce_state_t state_reg, state_next;
    logic [CW-1:0] clr_reg, clr_next;
    logic [2:0]    dk_reg, dk_next;
    logic          done_reg;

    logic [OPCODE_W-1:0]   op_reg;
    logic [FW-1:0]         oa_reg, ob_reg, ia_reg, ib_reg, ic_reg, id_reg;
    logic [LW-1:0]         li_reg;
    logic [XW-1:0]         t_reg;
    logic [TW-1:0]         pre_reg;
    logic [SAMPLE_W-1:0]   smp_reg;
    logic [FLAG_IDX_W-1:0] rawc_reg, rawd_reg;
    logic                  fa_reg, fb_reg, fc_reg, fd_reg;
    plce_rsp_t             result_reg;

    logic          f_we, f_wdata, f_rd0, f_rd1;
    logic [FW-1:0] f_waddr, f_ra0, f_ra1;
    logic          l_we, l_wdata, l_rd;
    logic          t_we;
    logic [TW-1:0] t_wdata, t_rd, tmr_new;
    logic [FW:0]   dec_sum;
    logic [FW-1:0] dec_addr;
    logic          clr_fl, clr_la, clr_tm;
    plce_ctl_t     ctl;

    plce_ram_2r #(.DEPTH(NUM_FLAGS)) u_flags (
        .clk    (clk),
        .we     (f_we),
        .waddr  (f_waddr),
        .wdata  (f_wdata),
        .raddr0 (f_ra0),
        .raddr1 (f_ra1),
        .rdata0 (f_rd0),
        .rdata1 (f_rd1)
    );

    plce_ram_1r #(.WIDTH(1), .DEPTH(NUM_LATCHES)) u_latches (
        .clk   (clk),
        .we    (l_we),
        .waddr ((state_reg == ST_CLEAR) ? clr_reg[LW-1:0] : li_reg),
        .wdata (l_wdata),
        .raddr (li_reg),
        .rdata (l_rd)
    );

    plce_ram_1r #(.WIDTH(TW), .DEPTH(NUM_TIMERS)) u_timers (
        .clk   (clk),
        .we    (t_we),
        .waddr ((state_reg == ST_CLEAR) ? clr_reg[XW-1:0] : t_reg),
        .wdata (t_wdata),
        .raddr (t_reg),
        .rdata (t_rd)
    );

    plce_exec u_exec (
        .op       (op_reg),
        .fa       (fa_reg),
        .fb       (fb_reg),
        .fc       (fc_reg),
        .fd       (fd_reg),
        .fo       (f_rd0),
        .ia_is_oa (ia_reg == oa_reg),
        .lat      (l_rd),
        .nz       (t_rd != '0),
        .smp      (smp_reg),
        .raw_c    (rawc_reg),
        .raw_d    (rawd_reg),
        .ctl      (ctl)
    );

    assign clr_fl = {1'b0, clr_reg} < (CW+1)'(NUM_FLAGS);
    assign clr_la = {1'b0, clr_reg} < (CW+1)'(NUM_LATCHES);
    assign clr_tm = {1'b0, clr_reg} < (CW+1)'(NUM_TIMERS);

    assign tmr_new = ctl.tmr_load ? pre_reg :
                     ctl.tmr_dec  ? t_rd - TW'(1) : t_rd;

    // decoder flags wrap past the top of the store
    assign dec_sum  = {1'b0, oa_reg} + (FW+1)'(dk_reg);
    assign dec_addr = (dec_sum >= (FW+1)'(NUM_FLAGS)) ?
                      FW'(dec_sum - (FW+1)'(NUM_FLAGS)) : dec_sum[FW-1:0];

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        dk_next    = dk_reg;
        f_we       = 1'b0;
        f_waddr    = oa_reg;
        f_wdata    = 1'b0;
        f_ra0      = oa_reg;
        f_ra1      = ob_reg;
        l_we       = 1'b0;
        l_wdata    = 1'b0;
        t_we       = 1'b0;
        t_wdata    = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                f_we    = clr_fl;
                f_waddr = clr_reg[FW-1:0];
                l_we    = clr_la;
                t_we    = clr_tm;
                clr_next = clr_reg + CW'(1);
                if (clr_reg == CW'(CLR_LEN - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_RD1;
                end
            end
            ST_RD1:
            begin
                f_ra0      = ia_reg;
                f_ra1      = ib_reg;
                state_next = ST_RD2;
            end
            ST_RD2:
            begin
                f_ra0      = ic_reg;
                f_ra1      = id_reg;
                state_next = ST_RD3;
            end
            ST_RD3:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                f_we    = ctl.wr_oa;
                f_wdata = ctl.oa_val;
                l_we    = 1'b1;
                l_wdata = ctl.lat_val;
                t_we    = 1'b1;
                t_wdata = tmr_new;
                dk_next = '0;
                if (ctl.demux)
                begin
                    state_next = ST_DEC;
                end
                else if (ctl.wr_ob)
                begin
                    state_next = ST_WOB;
                end
                else
                begin
                    state_next = ST_RB;
                end
            end
            ST_WOB:
            begin
                f_we       = 1'b1;
                f_waddr    = ob_reg;
                state_next = ST_RB;
            end
            ST_DEC:
            begin
                f_we    = 1'b1;
                f_waddr = dec_addr;
                f_wdata = (dk_reg == {fc_reg, fb_reg, fa_reg});
                dk_next = dk_reg + 3'd1;
                if (dk_reg == 3'(DECODE_SPAN - 1))
                begin
                    state_next = ST_RB;
                end
            end
            ST_RB:
            begin
                state_next = ST_CAP;
            end
            ST_CAP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            dk_reg    <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            dk_reg    <= dk_next;
            done_reg  <= (state_reg == ST_CAP);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            op_reg   <= cmd.opcode;
            oa_reg   <= FW'(fold_index(16'(cmd.out_a), 17'(NUM_FLAGS)));
            ob_reg   <= FW'(fold_index(16'(cmd.out_b), 17'(NUM_FLAGS)));
            ia_reg   <= FW'(fold_index(16'(cmd.in_a), 17'(NUM_FLAGS)));
            ib_reg   <= FW'(fold_index(16'(cmd.in_b), 17'(NUM_FLAGS)));
            ic_reg   <= FW'(fold_index(16'(cmd.in_c), 17'(NUM_FLAGS)));
            id_reg   <= FW'(fold_index(16'(cmd.in_d), 17'(NUM_FLAGS)));
            li_reg   <= LW'(fold_index(16'(cmd.latch_index), 17'(NUM_LATCHES)));
            t_reg    <= XW'(fold_index(16'(cmd.timer_index), 17'(NUM_TIMERS)));
            pre_reg  <= TW'(cmd.preset_time);
            smp_reg  <= cmd.analog_sample;
            rawc_reg <= cmd.in_c;
            rawd_reg <= cmd.in_d;
        end
        if (state_reg == ST_RD2)
        begin
            fa_reg <= f_rd0;
            fb_reg <= f_rd1;
        end
        if (state_reg == ST_RD3)
        begin
            fc_reg <= f_rd0;
            fd_reg <= f_rd1;
        end
        if (state_reg == ST_EXEC)
        begin
            result_reg.counter_after  <= COUNT_W'(tmr_new);
            result_reg.first_in_value <= fa_reg;
        end
        if (state_reg == ST_CAP)
        begin
            result_reg.first_out_value  <= f_rd0;
            result_reg.second_out_value <= f_rd1;
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* rtl/plce_checker.sv */
module plce_checker
    import plce_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input logic      done,
    input plce_rsp_t result
);

    // a result only appears once the engine is free again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("engine not busy after accepting an item");

    a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$isunknown(result.counter_after))
        else $error("unknown counter in result");

endmodule

bind plc_logic_instruction_engine plce_checker u_plce_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
    import plce_pkg::*;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    logic      done;
    plce_cmd_t cmd = '0;
    plce_rsp_t result;

    plc_logic_instruction_engine uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    // mirror of the flag, latch and timer stores; expected responses in order
    class plc_scoreboard;
        bit          flags   [1024];
        bit          latches [256];
        bit [15:0]   timers  [64];
        plce_rsp_t   pending [$];
        int unsigned checked;
        int unsigned errors;

        function new();
            foreach (flags[i]) flags[i] = 1'b0;
            foreach (latches[i]) latches[i] = 1'b0;
            foreach (timers[i]) timers[i] = '0;
            checked = 0;
            errors = 0;
        endfunction

        task report(input string msg);
            $display("%0t mismatch: %s", $realtime, msg);
            errors++;
        endtask

        // counts down unless already at zero; true when it counted
        function bit count_down(input bit [5:0] t);
            if (timers[t] == 16'd0)
                return 1'b0;
            timers[t] = timers[t] - 16'd1;
            return 1'b1;
        endfunction

        // running timer holds output low, expired timer passes data through
        function void gate_out(input bit [5:0] t, input bit [9:0] oa, input bit [9:0] src);
            if (count_down(t))
                flags[oa] = 1'b0;
            else
                flags[oa] = flags[src];
        endfunction

        function void note_cmd(input plce_cmd_t c);
            bit [9:0]    oa, ob, ia, ib, ic, id;
            bit [7:0]    li;
            bit [5:0]    t;
            bit [15:0]   pre;
            int unsigned smp, thr_lo, thr_hi, sel;
            bit          in_a_before;
            plce_rsp_t   e;
            oa = c.out_a;
            ob = c.out_b;
            ia = c.in_a;
            ib = c.in_b;
            ic = c.in_c;
            id = c.in_d;
            li = c.latch_index;
            t = c.timer_index;
            pre = c.preset_time;
            smp = c.analog_sample;
            thr_lo = c.in_c;
            thr_hi = c.in_d;
            in_a_before = flags[ia];
            case (c.opcode)
                OP_SET: if (flags[ia]) flags[oa] = 1'b1;
                OP_CLR: if (flags[ia]) flags[oa] = 1'b0;
                OP_COPY: flags[oa] = flags[ia];
                OP_TOGGLE:
                begin
                    if (!flags[ia])
                        void'(count_down(t));
                    else
                    begin
                        if (!count_down(t))
                            flags[oa] = !flags[oa];
                        timers[t] = pre;
                    end
                end
                OP_DELAY1:
                begin
                    if (flags[ib])
                    begin
                        timers[t] = pre;
                        flags[oa] = 1'b0;
                    end
                    else if (count_down(t))
                        flags[oa] = 1'b0;
                    else
                        flags[oa] = flags[ia];
                end
                OP_DELAY2:
                begin
                    if (flags[ib])
                        gate_out(t, oa, ia);
                    else
                    begin
                        flags[oa] = 1'b0;
                        timers[t] = pre;
                    end
                end
                OP_DELAY3:
                begin
                    if (flags[ia])
                        gate_out(t, oa, ia);
                    else
                    begin
                        flags[oa] = 1'b0;
                        timers[t] = pre;
                    end
                end
                OP_DELAY4:
                begin
                    if (flags[ia] || flags[ib])
                        flags[oa] = !count_down(t);
                    else
                    begin
                        flags[oa] = 1'b0;
                        timers[t] = pre;
                    end
                end
                OP_DELAY5:
                begin
                    if (flags[ic])
                        gate_out(t, oa, ia);
                    else if (flags[id])
                        gate_out(t, oa, ib);
                    else
                    begin
                        flags[oa] = 1'b0;
                        timers[t] = pre;
                    end
                end
                OP_ABOVE:
                begin
                    if (!flags[oa])
                    begin
                        if (smp > thr_hi) flags[oa] = 1'b1;
                    end
                    else if (smp < thr_lo)
                        flags[oa] = 1'b0;
                end
                OP_BELOW:
                begin
                    if (!flags[oa])
                    begin
                        if (smp < thr_hi) flags[oa] = 1'b1;
                    end
                    else if (smp > thr_lo)
                        flags[oa] = 1'b0;
                end
                OP_PULSE:
                begin
                    if (!flags[ia])
                        latches[li] = 1'b0;
                    if (count_down(t))
                        flags[oa] = 1'b1;
                    else
                    begin
                        flags[oa] = 1'b0;
                        if (!latches[li] && flags[ia])
                        begin
                            flags[oa] = 1'b1;
                            latches[li] = 1'b1;
                            timers[t] = pre;
                        end
                    end
                end
                OP_OR: flags[oa] = flags[ia] || flags[ib];
                OP_AND: flags[oa] = flags[ia] && flags[ib];
                OP_NOT: flags[oa] = !flags[ia];
                OP_DEMUX:
                begin
                    sel = {flags[ic], flags[ib], flags[ia]};
                    for (int k = 0; k < DECODE_SPAN; k++)
                        flags[10'(oa + k)] = 1'b0;
                    flags[10'(oa + sel)] = 1'b1;
                end
                OP_ZERO: flags[oa] = 1'b0;
                OP_ONE: flags[oa] = 1'b1;
                OP_LOCKOUT:
                begin
                    if (latches[li])
                    begin
                        if (count_down(t))
                        begin
                            if (flags[ia] || flags[ib]) timers[t] = pre;
                        end
                        else
                            latches[li] = 1'b0;
                        flags[oa] = 1'b0;
                        flags[ob] = 1'b0;
                    end
                    else if (flags[ia] && flags[ib])
                    begin
                        latches[li] = 1'b1;
                        timers[t] = pre;
                        flags[oa] = 1'b0;
                        flags[ob] = 1'b0;
                    end
                end
                default: ;
            endcase
            e.first_out_value = flags[oa];
            e.second_out_value = flags[ob];
            e.counter_after = timers[t];
            e.first_in_value = in_a_before;
            pending.push_back(e);
        endfunction

        task check_rsp(input plce_rsp_t r);
            plce_rsp_t e;
            if (pending.size() == 0)
            begin
                report("result with nothing pending");
                return;
            end
            e = pending.pop_front();
            checked++;
            if (r.first_out_value !== e.first_out_value)
                report($sformatf("first_out_value %b, want %b", r.first_out_value,
                                 e.first_out_value));
            if (r.second_out_value !== e.second_out_value)
                report($sformatf("second_out_value %b, want %b", r.second_out_value,
                                 e.second_out_value));
            if (r.counter_after !== e.counter_after)
                report($sformatf("counter_after %h, want %h", r.counter_after,
                                 e.counter_after));
            if (r.first_in_value !== e.first_in_value)
                report($sformatf("first_in_value %b, want %b", r.first_in_value,
                                 e.first_in_value));
        endtask
    endclass

    plc_scoreboard sb = new();
    int unsigned   n_sent = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_rsp(result);
    end

    // mostly a small window of flags (with the top end for wrap), sometimes anywhere
    function automatic logic [9:0] pick_flag();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 7) return 10'($urandom_range(0, 15));
        if (r == 7) return 10'($urandom_range(1012, 1023));
        return 10'($urandom);
    endfunction

    function automatic plce_cmd_t rand_cmd();
        plce_cmd_t c;
        c = '0;
        c.opcode = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, 18));
        c.out_a = pick_flag();
        c.out_b = pick_flag();
        c.in_a = pick_flag();
        c.in_b = pick_flag();
        c.in_c = $urandom_range(0, 1) ? pick_flag() : 10'($urandom);
        c.in_d = $urandom_range(0, 1) ? pick_flag() : 10'($urandom_range(0, 300));
        c.latch_index = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
        c.timer_index = ($urandom_range(0, 4) != 0) ? 6'($urandom_range(0, 3)) : 6'($urandom);
        case ($urandom_range(0, 9))
            0, 1: c.preset_time = 16'($urandom);
            2: c.preset_time = 16'hFFFF;
            default: c.preset_time = 16'($urandom_range(0, 5));
        endcase
        c.analog_sample = 8'($urandom);
        return c;
    endfunction

    function automatic plce_cmd_t mk(input plce_op_e op, input int oa, input int ob,
                                     input int ia, input int ib, input int ic,
                                     input int id, input int li, input int ti,
                                     input int pre, input int smp);
        plce_cmd_t c;
        c.opcode = op;
        c.out_a = 10'(oa);
        c.out_b = 10'(ob);
        c.in_a = 10'(ia);
        c.in_b = 10'(ib);
        c.in_c = 10'(ic);
        c.in_d = 10'(id);
        c.latch_index = 8'(li);
        c.timer_index = 6'(ti);
        c.preset_time = 16'(pre);
        c.analog_sample = 8'(smp);
        return c;
    endfunction

    task send_cmd(input plce_cmd_t c);
        cmd <= c;
        start <= 1'b1;
        do @(posedge clk); while (busy);
        sb.note_cmd(c);
        n_sent++;
    endtask

    task maybe_idle(input bit quiet);
        if (!quiet && $urandom_range(0, 99) < 8)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    initial
    begin
        plce_cmd_t dir [$];
        plce_cmd_t c;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        dir.push_back(mk(OP_ONE, 1023, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(mk(OP_SET, 5, 1023, 1023, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(mk(OP_COPY, 6, 5, 5, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(mk(OP_CLR, 5, 0, 6, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(mk(OP_TOGGLE, 7, 0, 6, 0, 0, 0, 0, 63, 65535, 0));
        dir.push_back(mk(OP_TOGGLE, 7, 0, 6, 0, 0, 0, 0, 63, 2, 0));
        dir.push_back(mk(OP_DELAY1, 8, 0, 6, 1023, 0, 0, 0, 1, 3, 0));
        dir.push_back(mk(OP_DELAY2, 8, 0, 6, 6, 0, 0, 0, 1, 2, 0));
        dir.push_back(mk(OP_DELAY3, 8, 0, 6, 0, 0, 0, 0, 2, 1, 0));
        dir.push_back(mk(OP_DELAY4, 9, 0, 0, 6, 0, 0, 0, 2, 0, 0));
        dir.push_back(mk(OP_DELAY5, 9, 0, 6, 0, 0, 6, 0, 3, 4, 0));
        dir.push_back(mk(OP_ABOVE, 10, 0, 0, 0, 0, 0, 0, 0, 0, 255));
        dir.push_back(mk(OP_ABOVE, 10, 0, 0, 0, 1023, 1023, 0, 0, 0, 0));
        dir.push_back(mk(OP_BELOW, 11, 0, 0, 0, 1023, 1023, 0, 0, 0, 255));
        dir.push_back(mk(OP_PULSE, 12, 0, 6, 0, 0, 0, 255, 4, 3, 0));
        dir.push_back(mk(OP_PULSE, 12, 0, 6, 0, 0, 0, 255, 4, 3, 0));
        dir.push_back(mk(OP_OR, 13, 0, 0, 6, 0, 0, 0, 0, 0, 0));
        dir.push_back(mk(OP_AND, 14, 0, 6, 1023, 0, 0, 0, 0, 0, 0));
        dir.push_back(mk(OP_NOT, 15, 0, 14, 0, 0, 0, 0, 0, 0, 0));
        // decoder spans the top of the store and wraps to the bottom
        dir.push_back(mk(OP_DEMUX, 1020, 0, 6, 0, 1023, 0, 0, 0, 0, 0));
        dir.push_back(mk(OP_LOCKOUT, 20, 21, 6, 1023, 0, 0, 7, 5, 2, 0));
        dir.push_back(mk(OP_LOCKOUT, 20, 21, 6, 1023, 0, 0, 7, 5, 2, 0));
        dir.push_back(mk(OP_ZERO, 1023, 0, 1023, 0, 0, 0, 0, 0, 0, 0));
        c = mk(OP_ZERO, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        c.opcode = 5'd31;
        dir.push_back(c);

        foreach (dir[i])
            send_cmd(dir[i]);
        for (int i = 0; i < 1900; i++)
        begin
            maybe_idle(i >= 700 && i < 1000);
            send_cmd(rand_cmd());
        end
        start <= 1'b0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        $display("Sent %0d instructions (directed and random over all opcodes),", n_sent);
        $display("checked %0d responses, %0d mismatches.", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("timeout");
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
